// File: rtl/megd_pkg.sv
// Shared types and constants for the modem escape guard detector.
package megd_pkg;

   // Configuration register indexes
   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CSR_ESCAPE_CHAR = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_GUARD_MS    = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_XONXOFF_EN  = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_ECHO_EN     = 2'd3;
   localparam int CsrDataWidth = 16;

   // Register reset values
   localparam logic [7:0]  ESCAPE_CHAR_RESET = 8'd43;
   localparam logic [15:0] GUARD_MS_RESET    = 16'd800;

   // Byte codes and counter limits
   localparam logic [7:0]  BYTE_XOFF = 8'd19;
   localparam logic [7:0]  BYTE_XON  = 8'd17;
   localparam logic [2:0]  PLUS_MAX  = 3'd4;
   localparam logic [2:0]  PLUS_ARM  = 3'd3;
   localparam logic [16:0] QUIET_MAX = 17'h1FFFF;

   // Item kinds on the request channel
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic [7:0]  escape_char;
      logic [15:0] guard_ms;
      logic        xonxoff_enable;
      logic        echo_enable;
   } megd_cfg_type;

   typedef struct packed {
      logic       forward_valid;
      logic [7:0] forward_byte;
      logic       echo_valid;
      logic       xon_state;
      logic       escape_detected;
   } megd_result_type;

endpackage

// File: rtl/megd_csr.sv
// Configuration registers of the modem escape guard detector.
module megd_csr
   import megd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output megd_cfg_type             cfg
);

   megd_cfg_type cfg_ff;
   megd_cfg_type cfg_in;

   assign csr_ready = 1'b1;

   // Decode one write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ESCAPE_CHAR: cfg_in.escape_char    = csr_wdata[7:0];
            CSR_GUARD_MS:    cfg_in.guard_ms       = csr_wdata[15:0];
            CSR_XONXOFF_EN:  cfg_in.xonxoff_enable = csr_wdata[0];
            CSR_ECHO_EN:     cfg_in.echo_enable    = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.escape_char    <= ESCAPE_CHAR_RESET;
         cfg_ff.guard_ms       <= GUARD_MS_RESET;
         cfg_ff.xonxoff_enable <= 1'b0;
         cfg_ff.echo_enable    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/megd_core.sv
// Escape run tracking, guard timers and flow control state, one item per step.
module megd_core
   import megd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic            cmd,
   input  logic [7:0]      rx_byte,
   input  megd_cfg_type    cfg,
   output megd_result_type result
);

   logic [2:0]  plus_count_ff, plus_count_in;
   logic [16:0] quiet_ticks_ff, quiet_ticks_in;
   logic [15:0] expire_remaining_ff, expire_remaining_in;
   logic        expire_armed_ff, expire_armed_in;
   logic        xon_flag_ff, xon_flag_in;

   logic is_escape;
   logic guard_met;
   logic forward;

   assign is_escape = (rx_byte == cfg.escape_char);
   assign guard_met = (quiet_ticks_ff > {1'b0, cfg.guard_ms});

   // Next state and result for the current item
   always_comb begin
      plus_count_in       = plus_count_ff;
      quiet_ticks_in      = quiet_ticks_ff;
      expire_remaining_in = expire_remaining_ff;
      expire_armed_in     = expire_armed_ff;
      xon_flag_in         = xon_flag_ff;
      forward             = 1'b0;
      result              = '0;

      if (cmd == CMD_TICK) begin
         // quiet time saturates, armed countdown fires at zero
         if (quiet_ticks_ff != QUIET_MAX) begin
            quiet_ticks_in = quiet_ticks_ff + 17'd1;
         end
         if (expire_armed_ff) begin
            if (expire_remaining_ff == 16'd0) begin
               expire_armed_in = 1'b0;
               if (plus_count_ff == PLUS_ARM) begin
                  plus_count_in          = 3'd0;
                  result.escape_detected = 1'b1;
               end
            end else begin
               expire_remaining_in = expire_remaining_ff - 16'd1;
            end
         end
      end else begin
         // escape run counting
         if (is_escape) begin
            if ((plus_count_ff != 3'd0 || guard_met) && plus_count_ff < PLUS_MAX) begin
               plus_count_in = plus_count_ff + 3'd1;
            end
         end else begin
            plus_count_in  = 3'd0;
            quiet_ticks_in = 17'd0;
         end

         // software flow control bytes are swallowed when XON/XOFF is enabled
         forward = 1'b1;
         if (cfg.xonxoff_enable && rx_byte == BYTE_XOFF) begin
            xon_flag_in = 1'b0;
            forward     = 1'b0;
         end else if (cfg.xonxoff_enable && rx_byte == BYTE_XON) begin
            xon_flag_in = 1'b1;
            forward     = 1'b0;
         end

         // every byte re-evaluates the expiry countdown
         expire_armed_in     = (plus_count_in == PLUS_ARM);
         expire_remaining_in = (plus_count_in == PLUS_ARM) ? cfg.guard_ms : 16'd0;

         result.forward_valid = forward;
         result.forward_byte  = forward ? rx_byte : 8'd0;
         result.echo_valid    = forward && cfg.echo_enable;
      end
      result.xon_state = xon_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_count_ff       <= 3'd0;
         quiet_ticks_ff      <= QUIET_MAX;
         expire_remaining_ff <= 16'd0;
         expire_armed_ff     <= 1'b0;
         xon_flag_ff         <= 1'b1;
      end else if (step) begin
         plus_count_ff       <= plus_count_in;
         quiet_ticks_ff      <= quiet_ticks_in;
         expire_remaining_ff <= expire_remaining_in;
         expire_armed_ff     <= expire_armed_in;
         xon_flag_ff         <= xon_flag_in;
      end
   end

   // Count never passes its saturation point
   a_plus_sat: assert property (@(posedge clock) disable iff (reset)
      plus_count_ff <= PLUS_MAX)
      else $error("plus count above saturation");

   // An armed countdown always belongs to a run of exactly three
   a_armed_run: assert property (@(posedge clock) disable iff (reset)
      expire_armed_ff |-> plus_count_ff == PLUS_ARM)
      else $error("countdown armed without a run of three");

   // A disarmed countdown holds no leftover ticks
   a_disarmed_zero: assert property (@(posedge clock) disable iff (reset)
      !expire_armed_ff |-> expire_remaining_ff == 16'd0)
      else $error("disarmed countdown not cleared");

   // A detected escape clears the run
   a_escape_clears: assert property (@(posedge clock) disable iff (reset)
      step && result.escape_detected |=> plus_count_ff == 3'd0 && !expire_armed_ff)
      else $error("escape detected but run not cleared");

endmodule

// File: rtl/modem_escape_guard_detector_top.sv
// Top level of the modem escape guard detector: input stage, core and result register.
//
// Usage:
//   req_ channel carries one item per handshake: req_cmd 0 is a serial byte in
//   req_rx_byte, req_cmd 1 is a one millisecond tick. Every item gives exactly
//   one result item on the rsp_ channel, in order.
//   csr_ channel, always ready, writes the escape character, guard time, XON/XOFF and
//   echo enable. Users must write it only while the block is idle; not enforced.
// Datapath and throughput:
//   An item is captured in the input register, worked through the core's
//   compare and counter logic and lands in the result register, which
//   drives rsp_valid. One item per cycle is sustained while rsp_ready stays
//   high, set by the core updating its state once per accepted item.
// Reset:
//   Synchronous, active high. Registers return to their defaults (escape 43,
//   guard 800 ticks, flow control and echo off), the run count clears, the
//   quiet time starts as already satisfied and the flow state is on.
// Stalls:
//   While rsp_ready is low the result register holds, the input register
//   holds its item and req_ready drops once both are full.
module modem_escape_guard_detector_top
   import megd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_cmd,
   input  logic [7:0]               req_rx_byte,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_forward_valid,
   output logic [7:0]               rsp_forward_byte,
   output logic                     rsp_echo_valid,
   output logic                     rsp_xon_state,
   output logic                     rsp_escape_detected,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   megd_cfg_type    cfg;
   megd_result_type core_result;

   logic            in_valid_ff;
   logic            in_cmd_ff;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff;
   megd_result_type out_result_ff;
   logic            advance;

   megd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input item moves on when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   megd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .cmd     (in_cmd_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_cmd;
         in_byte_ff <= req_rx_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_forward_valid   = out_result_ff.forward_valid;
   assign rsp_forward_byte    = out_result_ff.forward_byte;
   assign rsp_echo_valid      = out_result_ff.echo_valid;
   assign rsp_xon_state       = out_result_ff.xon_state;
   assign rsp_escape_detected = out_result_ff.escape_detected;

   // A held result is not overwritten while the receiver stalls
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !advance)
      else $error("result register overwritten during stall");

   // A stalled input item is kept until it moves on
   a_input_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input item lost while stalled");

   // Every item that moves on shows up as a result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("item advanced without a result");

endmodule

// File: tb/sv/tb_modem_escape_guard_detector_top.sv
// Self-checking testbench for the modem escape guard detector top level.
module tb_modem_escape_guard_detector_top;
   timeunit 1ns;
   timeprecision 1ps;

   import megd_pkg::*;

   localparam int CLOCK_PERIOD_NS = 12;
   localparam int RESET_CYCLES    = 4;
   localparam int TOTAL_ITEMS     = 1350;
   localparam int SETTLE_CYCLES   = 4;
   localparam int MAX_REPORTS     = 10;
   localparam int DIRECTED_ROWS   = 28;
   // ~1400 items, each at worst the longest send gap plus the longest result
   // stall, stay well below this limit.
   localparam int CYCLE_LIMIT     = 1_000_000;

   typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_type;

   typedef struct packed {
      logic            known;
      megd_result_type result;
   } result_plan_type;

   typedef struct packed {
      step_kind_type   kind;
      megd_cfg_type    cfg;
      logic            cmd;
      logic [7:0]      data;
      logic            known;
      megd_result_type result;
   } directed_step_type;

   localparam megd_cfg_type    CFG_NONE  = '0;
   localparam megd_result_type NO_RESULT = '0;

   // Clock and DUT ports
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   logic                     req_cmd     = CMD_BYTE;
   logic [7:0]               req_rx_byte = '0;

   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   logic                     rsp_forward_valid;
   logic [7:0]               rsp_forward_byte;
   logic                     rsp_echo_valid;
   logic                     rsp_xon_state;
   logic                     rsp_escape_detected;

   logic                     csr_valid   = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index   = CSR_ESCAPE_CHAR;
   logic [CsrDataWidth-1:0]  csr_wdata   = '0;

   always #(CLOCK_PERIOD_NS / 2.0) clock = ~clock;

   modem_escape_guard_detector_top u_dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_cmd,
      .req_rx_byte,
      .rsp_valid,
      .rsp_ready,
      .rsp_forward_valid,
      .rsp_forward_byte,
      .rsp_echo_valid,
      .rsp_xon_state,
      .rsp_escape_detected,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata
   );

   // Directed items: plain escape run from reset, saturation, early escape,
   // byte extremes, flow bytes, zero guard, escape char as a flow byte.
   directed_step_type directed_rows [DIRECTED_ROWS] = '{
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd43,  1'b1, '{1'b1, 8'd43,  1'b0, 1'b1, 1'b0}},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd43,  1'b1, '{1'b1, 8'd43,  1'b0, 1'b1, 1'b0}},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd43,  1'b1, '{1'b1, 8'd43,  1'b0, 1'b1, 1'b0}},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd43,  1'b1, '{1'b1, 8'd43,  1'b0, 1'b1, 1'b0}},
      '{STEP_ITEM, CFG_NONE, CMD_TICK, 8'hFF,  1'b1, '{1'b0, 8'd0,   1'b0, 1'b1, 1'b0}},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd43,  1'b1, '{1'b1, 8'd43,  1'b0, 1'b1, 1'b0}},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd65,  1'b1, '{1'b1, 8'd65,  1'b0, 1'b1, 1'b0}},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd43,  1'b1, '{1'b1, 8'd43,  1'b0, 1'b1, 1'b0}},
      '{STEP_ITEM, CFG_NONE, CMD_TICK, 8'h00,  1'b1, '{1'b0, 8'd0,   1'b0, 1'b1, 1'b0}},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd0,   1'b1, '{1'b1, 8'd0,   1'b0, 1'b1, 1'b0}},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd255, 1'b1, '{1'b1, 8'd255, 1'b0, 1'b1, 1'b0}},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd19,  1'b1, '{1'b1, 8'd19,  1'b0, 1'b1, 1'b0}},
      '{STEP_CFG, '{8'd43, 16'd0, 1'b1, 1'b1}, CMD_BYTE, 8'd0, 1'b0, NO_RESULT},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd19,  1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd17,  1'b1, '{1'b0, 8'd0,   1'b0, 1'b1, 1'b0}},
      '{STEP_ITEM, CFG_NONE, CMD_TICK, 8'h5A,  1'b0, NO_RESULT},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd43,  1'b0, NO_RESULT},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd43,  1'b0, NO_RESULT},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd43,  1'b0, NO_RESULT},
      '{STEP_ITEM, CFG_NONE, CMD_TICK, 8'hA5,  1'b1, '{1'b0, 8'd0,   1'b0, 1'b1, 1'b1}},
      '{STEP_CFG, '{8'd17, 16'd1, 1'b1, 1'b0}, CMD_BYTE, 8'd0, 1'b0, NO_RESULT},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd17,  1'b0, NO_RESULT},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd17,  1'b0, NO_RESULT},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd17,  1'b0, NO_RESULT},
      '{STEP_ITEM, CFG_NONE, CMD_TICK, 8'h3C,  1'b0, NO_RESULT},
      '{STEP_ITEM, CFG_NONE, CMD_TICK, 8'hC3,  1'b0, NO_RESULT},
      '{STEP_CFG, '{8'd255, 16'd65535, 1'b0, 1'b1}, CMD_BYTE, 8'd0, 1'b0, NO_RESULT},
      '{STEP_ITEM, CFG_NONE, CMD_BYTE, 8'd255, 1'b0, NO_RESULT}
   };

   // Detector state as the block should hold it
   megd_cfg_type model_cfg;
   logic [2:0]   model_plus;
   logic [16:0]  model_quiet;
   logic [15:0]  model_expire;
   logic         model_armed;
   logic         model_xon;

   result_plan_type pending_plans[$];
   megd_result_type expected_results[$];

   int unsigned error_count   = 0;
   int unsigned items_sent    = 0;
   int unsigned cycle_count   = 0;
   int unsigned req_gap_pct   = 20;
   int unsigned rsp_stall_pct = 20;
   int unsigned rsp_hold      = 0;

   function automatic void reset_model();
      model_cfg    = '{ESCAPE_CHAR_RESET, GUARD_MS_RESET, 1'b0, 1'b0};
      model_plus   = '0;
      model_quiet  = QUIET_MAX;
      model_expire = '0;
      model_armed  = 1'b0;
      model_xon    = 1'b1;
   endfunction

   // Advance the detector by one item and return the result it gives
   function automatic megd_result_type predict_escape_guard(input logic cmd,
                                                            input logic [7:0] data);
      megd_result_type res;
      logic            pass;
      res = '0;
      if (cmd == CMD_TICK) begin
         if (model_quiet != QUIET_MAX)
            model_quiet++;
         // expiry fires on the tick that finds the countdown at zero
         if (model_armed) begin
            if (model_expire == '0) begin
               model_armed = 1'b0;
               if (model_plus == PLUS_ARM) begin
                  model_plus = '0;
                  res.escape_detected = 1'b1;
               end
            end else begin
               model_expire--;
            end
         end
      end else begin
         // escape run counting: pending pluses or enough quiet time
         if (data == model_cfg.escape_char) begin
            if ((model_plus != '0 || model_quiet > {1'b0, model_cfg.guard_ms}) &&
                model_plus < PLUS_MAX)
               model_plus++;
         end else begin
            model_plus  = '0;
            model_quiet = '0;
         end
         // flow bytes are swallowed when XON/XOFF is enabled
         pass = 1'b1;
         if (model_cfg.xonxoff_enable && data == BYTE_XOFF) begin
            model_xon = 1'b0;
            pass      = 1'b0;
         end else if (model_cfg.xonxoff_enable && data == BYTE_XON) begin
            model_xon = 1'b1;
            pass      = 1'b0;
         end
         model_armed  = (model_plus == PLUS_ARM);
         model_expire = model_armed ? model_cfg.guard_ms : 16'd0;
         res.forward_valid = pass;
         res.forward_byte  = pass ? data : 8'd0;
         res.echo_valid    = pass && model_cfg.echo_enable;
      end
      res.xon_state = model_xon;
      return res;
   endfunction

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t ns: %s", $time, msg);
   endfunction

   function automatic void check_result(input megd_result_type want,
                                        input megd_result_type got);
      if (got.forward_valid !== want.forward_valid)
         note_error($sformatf("forward_valid mismatch: expected %b, got %b",
                              want.forward_valid, got.forward_valid));
      if (got.forward_byte !== want.forward_byte)
         note_error($sformatf("forward_byte mismatch: expected %h, got %h",
                              want.forward_byte, got.forward_byte));
      if (got.echo_valid !== want.echo_valid)
         note_error($sformatf("echo_valid mismatch: expected %b, got %b",
                              want.echo_valid, got.echo_valid));
      if (got.xon_state !== want.xon_state)
         note_error($sformatf("xon_state mismatch: expected %b, got %b",
                              want.xon_state, got.xon_state));
      if (got.escape_detected !== want.escape_detected)
         note_error($sformatf("escape_detected mismatch: expected %b, got %b",
                              want.escape_detected, got.escape_detected));
   endfunction

   // Mostly short gaps, some medium, a few long
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Serial byte biased toward flow codes and the escape character
   function automatic logic [7:0] serial_byte();
      case ($urandom_range(0, 9))
         0:       return BYTE_XON;
         1:       return BYTE_XOFF;
         2, 3:    return model_cfg.escape_char;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do
         b = serial_byte();
      while (b == model_cfg.escape_char);
      return b;
   endfunction

   function automatic megd_cfg_type random_config();
      megd_cfg_type cfg;
      int unsigned  pick;
      case ($urandom_range(0, 5))
         0:       cfg.escape_char = ESCAPE_CHAR_RESET;
         1:       cfg.escape_char = BYTE_XON;
         2:       cfg.escape_char = BYTE_XOFF;
         3:       cfg.escape_char = 8'h00;
         4:       cfg.escape_char = 8'hFF;
         default: cfg.escape_char = 8'($urandom_range(0, 255));
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 2)
         cfg.guard_ms = 16'd0;
      else if (pick < 7)
         cfg.guard_ms = 16'($urandom_range(1, 6));
      else if (pick < 9)
         cfg.guard_ms = 16'($urandom_range(7, 40));
      else
         cfg.guard_ms = 16'hFFFF;
      cfg.xonxoff_enable = 1'($urandom_range(0, 1));
      cfg.echo_enable    = 1'($urandom_range(0, 1));
      return cfg;
   endfunction

   // Offer one item and hold it until accepted, then maybe pause
   task automatic send_item(input logic cmd, input logic [7:0] data,
                            input logic known, input megd_result_type result);
      result_plan_type plan;
      plan.known  = known;
      plan.result = result;
      pending_plans.push_back(plan);
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_rx_byte <= data;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
      items_sent++;
      if ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   task automatic send_byte(input logic [7:0] data);
      send_item(CMD_BYTE, data, 1'b0, NO_RESULT);
   endtask

   task automatic send_tick();
      send_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
   endtask

   // Stop sending and wait until every result is in and the block is quiet
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_plans.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (csr_ready !== 1'b1);
      case (index)
         CSR_ESCAPE_CHAR: model_cfg.escape_char    = value[7:0];
         CSR_GUARD_MS:    model_cfg.guard_ms       = value;
         CSR_XONXOFF_EN:  model_cfg.xonxoff_enable = value[0];
         CSR_ECHO_EN:     model_cfg.echo_enable    = value[0];
         default: ;
      endcase
   endtask

   // Unused upper data bits carry noise; the block keeps only the low bits
   task automatic write_config(input megd_cfg_type cfg);
      write_reg(CSR_ESCAPE_CHAR, {8'($urandom_range(0, 255)), cfg.escape_char});
      write_reg(CSR_GUARD_MS, cfg.guard_ms);
      write_reg(CSR_XONXOFF_EN, {15'($urandom_range(0, 32767)), cfg.xonxoff_enable});
      write_reg(CSR_ECHO_EN, {15'($urandom_range(0, 32767)), cfg.echo_enable});
      csr_valid <= 1'b0;
   endtask

   // Non-escape lead-in, quiet ticks, an escape run, then ticks to expiry
   task automatic send_escape_attempt();
      int unsigned span;
      int unsigned quiet;
      int unsigned run;
      span  = (model_cfg.guard_ms > 30) ? 30 : model_cfg.guard_ms;
      repeat ($urandom_range(0, 3)) send_byte(plain_byte());
      quiet = ($urandom_range(0, 99) < 15) ? $urandom_range(0, span)
                                           : span + $urandom_range(1, 2);
      repeat (quiet) send_tick();
      run = ($urandom_range(0, 99) < 70) ? 3 : $urandom_range(1, 5);
      repeat (run) begin
         if ($urandom_range(0, 99) < 10)
            send_tick();
         send_byte(model_cfg.escape_char);
      end
      repeat (span + $urandom_range(1, 3)) begin
         if ($urandom_range(0, 99) < 5)
            send_byte(serial_byte());
         send_tick();
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 12)) begin
         if ($urandom_range(0, 1) == 1)
            send_tick();
         else
            send_byte(serial_byte());
      end
   endtask

   // Result side: random stall stretches
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_hold = gap_len() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Predict on each accepted item, compare each accepted result in order
   always @(posedge clock) begin : result_check
      result_plan_type plan;
      megd_result_type predicted;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = predict_escape_guard(req_cmd, req_rx_byte);
            plan = (pending_plans.size() != 0) ? pending_plans.pop_front() : '0;
            expected_results.push_back(plan.known ? plan.result : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0)
               note_error("result item arrived with none expected");
            else
               check_result(expected_results.pop_front(),
                            {rsp_forward_valid, rsp_forward_byte, rsp_echo_valid,
                             rsp_xon_state, rsp_escape_detected});
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
   end

   // Stimulus
   initial begin
      int unsigned  phase;
      int unsigned  phase_end;
      int unsigned  pick;
      megd_cfg_type cfg;
      phase = 0;
      reset_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == STEP_CFG) begin
            wait_idle();
            write_config(directed_rows[i].cfg);
         end else begin
            send_item(directed_rows[i].cmd, directed_rows[i].data,
                      directed_rows[i].known, directed_rows[i].result);
         end
      end

      // random phases, each under its own register setting
      while (items_sent < TOTAL_ITEMS) begin
         wait_idle();
         if (phase == 0)
            cfg = '{8'h00, 16'h0000, 1'b1, 1'b1};
         else
            cfg = random_config();
         write_config(cfg);
         if (phase % 4 == 1) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct   = $urandom_range(5, 50);
            rsp_stall_pct = $urandom_range(5, 50);
         end
         phase_end = items_sent + $urandom_range(120, 260);
         while (items_sent < phase_end && items_sent < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
               send_escape_attempt();
            else if (pick < 97)
               send_noise();
            else
               wait_idle();
         end
         phase++;
      end

      wait_idle();
      if (error_count == 0 && expected_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: files.f
rtl/megd_pkg.sv
rtl/megd_csr.sv
rtl/megd_core.sv
rtl/modem_escape_guard_detector_top.sv
tb/sv/tb_modem_escape_guard_detector_top.sv
